FILE: rtl/cauchy_erasure_parity_encoder_assert.svh
// Assertion macros shared by the parity encoder modules.
`ifndef CAUCHY_ERASURE_PARITY_ENCODER_ASSERT_SVH
`define CAUCHY_ERASURE_PARITY_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define CEPE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("parity encoder check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define CEPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("parity encoder check failed");

`endif

FILE: rtl/cepe_pkg.sv
// Shared types, constants and GF(2^8) functions for the Cauchy parity encoder.
package cepe_pkg;

  // Field polynomial x^8 + x^4 + x^3 + x^2 + 1.
  localparam logic [8:0] FIELD_POLY = 9'h11d;

  // Exponent that maps a nonzero field element to its inverse.
  localparam logic [7:0] INV_EXP = 8'd254;

  // The parity index port is 4 bits wide, so at most 16 lanes are ever read.
  localparam int LANE_LIMIT = 16;

  localparam int DEF_MAX_DATA_BLOCKS   = 16;
  localparam int DEF_MAX_PARITY_BLOCKS = 16;

  localparam logic [4:0] RESET_DATA_COUNT   = 5'd8;
  localparam logic [4:0] RESET_PARITY_COUNT = 5'd4;

  // Configuration register indexes.
  localparam logic CFG_DATA_COUNT   = 1'b0;
  localparam logic CFG_PARITY_COUNT = 1'b1;

  typedef logic [7:0] inv_table_t [256];

  // Per-cycle control that the top level hands to every lane.
  typedef struct packed {
    logic step;   // the input stage advances this cycle
    logic hit;    // the block index is below the data block count
    logic clear;  // the word ends a column
  } lane_ctl_t;

  // Load request from the top level to the output buffer.
  typedef struct packed {
    logic       load;
    logic       last_col;
    logic [4:0] count;
  } drain_ctl_t;

  // Carry-less multiply reduced by the field polynomial.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ FIELD_POLY[7:0]) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

  // Inverse by raising to the 254th power; zero maps to zero.
  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] result;
    logic [7:0] base;
    result = 8'd1;
    base   = a;
    for (int k = 0; k < 8; k++) begin
      if (INV_EXP[k]) result = gf_mul(result, base);
      base = gf_mul(base, base);
    end
    return result;
  endfunction

  function automatic inv_table_t build_inv_table();
    inv_table_t t;
    for (int v = 0; v < 256; v++) begin
      t[v] = gf_inv(8'(v));
    end
    return t;
  endfunction

  // Inverse table, evaluated at elaboration.
  localparam inv_table_t GF_INV = build_inv_table();

endpackage

FILE: rtl/cepe_lane.sv
// One parity lane: Cauchy coefficient lookup, field multiply and accumulator.
module cepe_lane #(
  parameter int LANE_IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cepe_pkg::lane_ctl_t  ctl,
  input  logic [7:0]           data_byte,
  input  logic [3:0]           block_index,
  input  logic [4:0]           data_count,
  input  logic [4:0]           parity_count,
  output logic [7:0]           acc_next
);

  logic [7:0] acc;
  logic [5:0] denom_sum;
  logic [7:0] denom;
  logic [7:0] coef;
  logic [7:0] prod;
  logic       active;

  // Denominator (i + n) xor j; it stays below 64.
  assign denom_sum = 6'(LANE_IDX) + {1'b0, data_count};
  assign denom     = {2'b00, denom_sum ^ {2'b00, block_index}};
  assign coef      = cepe_pkg::GF_INV[denom];
  assign prod      = cepe_pkg::gf_mul(coef, data_byte);

  // A lane at or above the parity count keeps its value.
  assign active   = ctl.hit && (5'(LANE_IDX) < parity_count);
  assign acc_next = active ? (acc ^ prod) : acc;

  // Accumulator clears when a column end word leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.step) begin
      acc <= ctl.clear ? 8'd0 : acc_next;
    end
  end

endmodule

FILE: rtl/cepe_drain.sv
// Output buffer that holds one column of parity bytes and sends them in order.
`include "cauchy_erasure_parity_encoder_assert.svh"

module cepe_drain #(
  parameter int NUM_LANES = cepe_pkg::LANE_LIMIT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cepe_pkg::drain_ctl_t  ctl,
  input  logic [7:0]            snap_in [NUM_LANES],
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            parity_byte,
  output logic [3:0]            parity_index,
  output logic                  run_last,
  output logic                  stripe_done
);

  logic       busy;
  logic [3:0] ptr;
  logic [4:0] count;
  logic       last_col;
  logic [7:0] snap [NUM_LANES];
  logic       take;

  // Head of the shift buffer is the current word.
  assign out_valid    = busy;
  assign parity_byte  = snap[0];
  assign parity_index = ptr;
  assign run_last     = busy && (({1'b0, ptr} + 5'd1) == count);
  assign stripe_done  = run_last && last_col;
  assign take         = busy && out_ready;

  // A new column may load when empty or when the last word leaves now.
  assign free = !busy || (out_ready && run_last);

  // Control state of the buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      ptr      <= '0;
      count    <= '0;
      last_col <= 1'b0;
    end else if (ctl.load) begin
      busy     <= 1'b1;
      ptr      <= '0;
      count    <= ctl.count;
      last_col <= ctl.last_col;
    end else if (take) begin
      if (run_last) begin
        busy <= 1'b0;
      end else begin
        ptr <= ptr + 4'd1;
      end
    end
  end

  // Parity bytes shift toward the head as words are taken.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      snap <= snap_in;
    end else if (take) begin
      for (int k = 0; k < NUM_LANES - 1; k++) begin
        snap[k] <= snap[k + 1];
      end
    end
  end

  `CEPE_ASSERT_NOW(a_load_when_free, ctl.load, free)
  `CEPE_ASSERT_NOW(a_ptr_in_range, busy, ({1'b0, ptr} < count))
  `CEPE_ASSERT_NEXT(a_empty_after_last, take && run_last && !ctl.load, !out_valid)

endmodule

FILE: rtl/cauchy_erasure_parity_encoder.sv
// A column end word is registered in the input register, then, when r > 0, loads its
// parity column into the output buffer, whose head drives the first parity byte out.
// Throughput: one data word per cycle unless a column end stalls the input register;
// parity words leave one per cycle while out_ready is high. A column end waits in
// the input register while the previous column still drains.
// Reset (synchronous): accumulators cleared, output buffer empty, n = 8, r = 4.
`include "cauchy_erasure_parity_encoder_assert.svh"

module cauchy_erasure_parity_encoder #(
  parameter int MAX_DATA_BLOCKS   = cepe_pkg::DEF_MAX_DATA_BLOCKS,
  parameter int MAX_PARITY_BLOCKS = cepe_pkg::DEF_MAX_PARITY_BLOCKS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic [3:0] block_index,
  input  logic       column_end,
  input  logic       final_column,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] parity_byte,
  output logic [3:0] parity_index,
  output logic       run_last,
  output logic       stripe_done
);

  localparam int NUM_LANES = (MAX_PARITY_BLOCKS < cepe_pkg::LANE_LIMIT) ?
                             MAX_PARITY_BLOCKS : cepe_pkg::LANE_LIMIT;

  logic [4:0] cfg_n;
  logic [4:0] cfg_r;
  logic [4:0] n_eff;
  logic [4:0] r_eff;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic [3:0] s1_j;
  logic       s1_col_end;
  logic       s1_final;
  logic       s1_adv;

  logic                 drain_free;
  cepe_pkg::lane_ctl_t  lane_ctl;
  cepe_pkg::drain_ctl_t drain_ctl;
  logic [7:0]           lane_next [NUM_LANES];

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_n <= cepe_pkg::RESET_DATA_COUNT;
      cfg_r <= cepe_pkg::RESET_PARITY_COUNT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cepe_pkg::CFG_DATA_COUNT:   cfg_n <= cfg_data;
        cepe_pkg::CFG_PARITY_COUNT: cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Counts saturated to what the block is built for.
  assign n_eff = (int'(cfg_n) > MAX_DATA_BLOCKS) ? 5'(MAX_DATA_BLOCKS) : cfg_n;
  assign r_eff = (int'(cfg_r) > NUM_LANES) ? 5'(NUM_LANES) : cfg_r;

  // Input register advances unless its column end finds the buffer busy.
  assign s1_adv   = s1_valid && (!s1_col_end || (r_eff == 5'd0) || drain_free);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte    <= data_byte;
      s1_j       <= block_index;
      s1_col_end <= column_end;
      s1_final   <= final_column;
    end
  end

  // Lane control and buffer load for the word in the input register.
  assign lane_ctl.step  = s1_adv;
  assign lane_ctl.hit   = ({1'b0, s1_j} < n_eff);
  assign lane_ctl.clear = s1_col_end;

  assign drain_ctl.load     = s1_adv && s1_col_end && (r_eff != 5'd0);
  assign drain_ctl.last_col = s1_final;
  assign drain_ctl.count    = r_eff;

  // All parity lanes update in parallel.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    cepe_lane #(
      .LANE_IDX (g)
    ) u_lane (
      .clk          (clk),
      .rst          (rst),
      .ctl          (lane_ctl),
      .data_byte    (s1_byte),
      .block_index  (s1_j),
      .data_count   (n_eff),
      .parity_count (r_eff),
      .acc_next     (lane_next[g])
    );
  end

  cepe_drain #(
    .NUM_LANES (NUM_LANES)
  ) u_drain (
    .clk          (clk),
    .rst          (rst),
    .ctl          (drain_ctl),
    .snap_in      (lane_next),
    .free         (drain_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parity_byte  (parity_byte),
    .parity_index (parity_index),
    .run_last     (run_last),
    .stripe_done  (stripe_done)
  );

  `CEPE_ASSERT_NEXT(a_accept_fills_stage, in_valid && in_ready, s1_valid)
  `CEPE_ASSERT_NEXT(a_stall_holds_stage, s1_valid && !s1_adv, s1_valid && $stable(s1_byte))
  `CEPE_ASSERT_NOW(a_load_on_column_end, drain_ctl.load, s1_valid && s1_col_end)

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the Cauchy erasure parity encoder.
module tb_top;

  typedef struct packed {
    logic [7:0] pbyte;
    logic [3:0] pidx;
    logic       last;
    logic       done;
  } parity_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = cepe_pkg::CFG_DATA_COUNT;
  logic [4:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = '0;
  logic [3:0] block_index = '0;
  logic       column_end = 1'b0;
  logic       final_column = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] parity_byte;
  logic [3:0] parity_index;
  logic       run_last;
  logic       stripe_done;

  cauchy_erasure_parity_encoder dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
    .block_index(block_index), .column_end(column_end), .final_column(final_column),
    .out_valid(out_valid), .out_ready(out_ready), .parity_byte(parity_byte),
    .parity_index(parity_index), .run_last(run_last), .stripe_done(stripe_done)
  );

  always #2 clk = ~clk;

  // Predictor state: running parity sums and the two count registers.
  logic [7:0]   parity_sum [16];
  logic [4:0]   data_count_reg = cepe_pkg::RESET_DATA_COUNT;
  logic [4:0]   parity_count_reg = cepe_pkg::RESET_PARITY_COUNT;
  parity_word_t parity_q [$];

  // Field tables built from the generator 2 under the 0x11d polynomial.
  logic [7:0] alog_tbl [0:509];
  int         log_tbl [0:255];

  int err_count = 0;
  int word_count = 0;
  bit sender_gaps = 1'b0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_cyc = 0;

  initial begin
    for (int i = 0; i < 16; i++) parity_sum[i] = '0;
  end

  function automatic void build_field_tables();
    logic [8:0] x;
    x = 9'd1;
    for (int k = 0; k < 255; k++) begin
      alog_tbl[k] = x[7:0];
      alog_tbl[k + 255] = x[7:0];
      log_tbl[x[7:0]] = k;
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ 9'h11d;
    end
  endfunction

  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    if (a == 8'd0 || b == 8'd0) return 8'd0;
    return alog_tbl[log_tbl[a] + log_tbl[b]];
  endfunction

  function automatic logic [7:0] gf_recip(input logic [7:0] a);
    if (a == 8'd0) return 8'd0;
    return alog_tbl[(255 - log_tbl[a]) % 255];
  endfunction

  // Fold one accepted data word into the parity sums and queue the column's parity.
  function automatic void absorb_data_word(input logic [7:0] b, input logic [3:0] j,
                                           input logic ce, input logic fc);
    int n_eff;
    int r_eff;
    parity_word_t w;
    n_eff = (data_count_reg > 5'd16) ? 16 : int'(data_count_reg);
    r_eff = (parity_count_reg > 5'd16) ? 16 : int'(parity_count_reg);
    if (int'(j) < n_eff) begin
      for (int i = 0; i < r_eff; i++) begin
        parity_sum[i] ^= gf_times(gf_recip(8'((i + n_eff) ^ int'(j))), b);
      end
    end
    if (ce) begin
      for (int i = 0; i < r_eff; i++) begin
        w.pbyte = parity_sum[i];
        w.pidx  = 4'(i);
        w.last  = (i == r_eff - 1);
        w.done  = (i == r_eff - 1) && fc;
        parity_q.push_back(w);
      end
      for (int i = 0; i < 16; i++) parity_sum[i] = '0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("tb_top: mismatch at %0t: %s", $realtime, msg);
  endtask

  // Send one data word; called and returning at a falling edge, valid left high.
  task automatic send_word(input logic [7:0] b, input logic [3:0] j,
                           input logic ce, input logic fc);
    if (sender_gaps && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid     = 1'b1;
    data_byte    = b;
    block_index  = j;
    column_end   = ce;
    final_column = fc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_data_word(b, j, ce, fc);
    word_count++;
    @(negedge clk);
  endtask

  // Let every queued parity word leave and the pipeline settle.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (parity_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == cepe_pkg::CFG_DATA_COUNT) data_count_reg = val;
    else parity_count_reg = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_counts(input logic [4:0] n, input logic [4:0] r);
    wait_idle();
    write_reg(cepe_pkg::CFG_DATA_COUNT, n);
    write_reg(cepe_pkg::CFG_PARITY_COUNT, r);
  endtask

  // Receiver ready: always, random stalls, or a fixed periodic pattern.
  always @(negedge clk) begin
    stall_cyc++;
    if (stall_mode == 0) begin
      out_ready = 1'b1;
    end else if (stall_mode == 1) begin
      if (stall_left > 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end else begin
      out_ready = (stall_cyc % 7) < 4;
    end
  end

  // Compare each accepted parity word with the oldest expectation.
  always @(posedge clk) begin
    parity_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (parity_q.size() == 0) begin
        report_mismatch($sformatf("unexpected parity word byte %0h index %0d",
                                  parity_byte, parity_index));
      end else begin
        want = parity_q.pop_front();
        if (parity_byte !== want.pbyte)
          report_mismatch($sformatf("parity_byte got %0h want %0h (index %0d)",
                                    parity_byte, want.pbyte, want.pidx));
        if (parity_index !== want.pidx)
          report_mismatch($sformatf("parity_index got %0d want %0d",
                                    parity_index, want.pidx));
        if (run_last !== want.last)
          report_mismatch($sformatf("run_last got %b want %b (index %0d)",
                                    run_last, want.last, want.pidx));
        if (stripe_done !== want.done)
          report_mismatch($sformatf("stripe_done got %b want %b (index %0d)",
                                    stripe_done, want.done, want.pidx));
      end
    end
  end

  // Reset counts: field extremes, ignored indexes and the flag corner cases.
  task automatic test_reset_counts();
    stall_mode  = 1;
    sender_gaps = 1'b1;
    send_word(8'h00, 4'd0, 1'b0, 1'b0);
    send_word(8'hff, 4'd1, 1'b0, 1'b0);
    send_word(8'h01, 4'd2, 1'b0, 1'b0);
    send_word(8'h80, 4'd7, 1'b0, 1'b0);
    // Index not below n is dropped; final column without a column end does nothing.
    send_word(8'h5a, 4'd9, 1'b0, 1'b0);
    send_word(8'h33, 4'd3, 1'b0, 1'b1);
    // An ignored word still ends the column.
    send_word(8'ha5, 4'd12, 1'b1, 1'b0);
    // Byte and column end on the same word, last column of the stripe.
    send_word(8'h7e, 4'd4, 1'b1, 1'b1);
  endtask

  // Count registers at their extremes, saturation, zero counts and a mid-column change.
  task automatic test_count_extremes();
    stall_mode  = 0;
    sender_gaps = 1'b0;
    set_counts(5'd16, 5'd16);
    send_word(8'hff, 4'd15, 1'b0, 1'b0);
    send_word(8'h80, 4'd0, 1'b1, 1'b1);
    set_counts(5'd1, 5'd1);
    send_word(8'hc3, 4'd0, 1'b1, 1'b0);
    send_word(8'h11, 4'd1, 1'b1, 1'b1);
    // No data blocks: the column end shows cleared sums.
    set_counts(5'd0, 5'd4);
    send_word(8'h42, 4'd0, 1'b1, 1'b1);
    // Oversized n saturates; zero parity blocks still clear the sums.
    set_counts(5'd31, 5'd0);
    send_word(8'h99, 4'd15, 1'b0, 1'b0);
    send_word(8'h2c, 4'd3, 1'b1, 1'b0);
    wait_idle();
    write_reg(cepe_pkg::CFG_PARITY_COUNT, 5'd31);
    send_word(8'h10, 4'd5, 1'b1, 1'b1);
    // Counts change while a column is open; the sums carry over.
    stall_mode = 2;
    set_counts(5'd8, 5'd4);
    send_word(8'h37, 4'd2, 1'b0, 1'b0);
    set_counts(5'd12, 5'd2);
    send_word(8'h6c, 4'd10, 1'b1, 1'b1);
  endtask

  // Random stripes under changing counts, with noise and broken columns mixed in.
  task automatic test_random_stripes();
    int start;
    int phase;
    int n_eff;
    int stripes;
    int cols;
    int len;
    bit rev;
    logic [4:0] n;
    logic [4:0] r;
    start = word_count;
    phase = 0;
    while (word_count - start < 450) begin
      case ($urandom_range(0, 9))
        0: n = 5'd0;
        1: n = 5'd31;
        2: n = 5'd16;
        default: n = 5'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 9))
        0: r = 5'd0;
        1: r = 5'($urandom_range(17, 31));
        2: r = 5'd16;
        default: r = 5'($urandom_range(1, 16));
      endcase
      wait_idle();
      if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(cepe_pkg::CFG_DATA_COUNT, n);
      write_reg(cepe_pkg::CFG_PARITY_COUNT, r);
      stall_mode  = phase % 3;
      sender_gaps = (phase % 4) != 1;
      n_eff = (data_count_reg > 5'd16) ? 16 : int'(data_count_reg);
      stripes = $urandom_range(1, 3);
      for (int s = 0; s < stripes; s++) begin
        cols = $urandom_range(1, 4);
        for (int c = 0; c < cols; c++) begin
          rev = 1'($urandom_range(0, 1));
          len = n_eff;
          // Occasionally cut the column short.
          if (len > 1 && $urandom_range(0, 9) == 0) len = $urandom_range(1, len - 1);
          if (len == 0) begin
            send_word(8'($urandom), 4'($urandom), 1'b1, c == cols - 1);
          end
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
              send_word(8'($urandom), 4'($urandom), $urandom_range(0, 3) == 0,
                        1'($urandom_range(0, 1)));
            send_word(8'($urandom), 4'(rev ? len - 1 - k : k), k == len - 1,
                      (k == len - 1) ? (c == cols - 1) : 1'($urandom_range(0, 1)));
          end
        end
      end
      phase++;
    end
  endtask

  initial begin
    build_field_tables();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_counts();
    test_count_extremes();
    test_random_stripes();
    in_valid = 1'b0;
    while (parity_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  // Run limit, well beyond the slowest legal run.
  initial begin
    #4000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cepe_pkg.sv
rtl/cepe_lane.sv
rtl/cepe_drain.sv
rtl/cauchy_erasure_parity_encoder.sv
test/tb_top.sv
